// ===== sv/wbg_pkg.sv =====
package wbg_pkg;

  localparam int NUM_CONSUMERS_DEF = 4;

  localparam logic [1:0] MODE_RESERVE  = 2'd0;
  localparam logic [1:0] MODE_BEGIN    = 2'd1;
  localparam logic [1:0] MODE_FALLBACK = 2'd2;

  localparam logic [1:0] CFG_MAX_DRAWS    = 2'd0;
  localparam logic [1:0] CFG_MAX_VERTICES = 2'd1;
  localparam logic [1:0] CFG_MAX_INDICES  = 2'd2;

  typedef enum logic [2:0] {
    RSN_NONE,
    RSN_INVALID_REQ,
    RSN_OVERFLOW,
    RSN_INVALID_FRAME,
    RSN_DRAW,
    RSN_VERTEX,
    RSN_INDEX
  } reason_t;

  typedef struct packed {
    logic [31:0] draws;
    logic [31:0] vertices;
    logic [31:0] indices;
  } triple_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  consumer;
    logic [31:0] item_count;
    triple_t     cost;
    logic        cost_valid;
    logic [31:0] frame_serial;
    logic        held_last_complete;
  } item_t;

  typedef struct packed {
    logic        req_ok;
    triple_t     req;
    logic [31:0] req_items;
    triple_t     acc;
    logic [31:0] acc_items;
    logic [31:0] accepts;
    logic [31:0] rejects;
  } entry_t;

  typedef struct packed {
    logic    granted;
    reason_t reason;
    logic    overflow;
  } decision_t;

  localparam entry_t ENTRY_CLEAR = '{req_ok: 1'b1, default: '0};

  function automatic logic [32:0] add33(input logic [31:0] a, input logic [31:0] b);
    return {1'b0, a} + {1'b0, b};
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== sv/wbg_ledger.sv =====
module wbg_ledger #(
  parameter int NUM_CONSUMERS = wbg_pkg::NUM_CONSUMERS_DEF,
  parameter int CW = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              we,
  input  logic [CW-1:0]     widx,
  input  wbg_pkg::entry_t   wdata,
  input  logic [CW-1:0]     ridx,
  output wbg_pkg::entry_t   rdata
);
  import wbg_pkg::*;

  entry_t entries [NUM_CONSUMERS];

  assign rdata = entries[ridx];

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int k = 0; k < NUM_CONSUMERS; k++) begin
        entries[k] <= ENTRY_CLEAR;
      end
    end else if (we) begin
      entries[widx] <= wdata;
    end
  end

endmodule

// ===== sv/wbg_admit.sv =====
module wbg_admit (
  input  wbg_pkg::item_t     item,
  input  logic               consumer_ok,
  input  wbg_pkg::entry_t    entry,
  input  wbg_pkg::triple_t   used,
  input  wbg_pkg::triple_t   max,
  input  logic               serial_nonzero,
  output wbg_pkg::decision_t dec,
  output wbg_pkg::entry_t    entry_next,
  output wbg_pkg::triple_t   used_next
);
  import wbg_pkg::*;

  logic [32:0] req_d, req_v, req_i, req_items;
  logic [32:0] cand_d, cand_v, cand_i;
  logic [32:0] acc_d, acc_v, acc_i, acc_items;
  logic        req_carry, cand_carry, acc_carry, frame_ok;
  reason_t     reason;

  assign req_d     = add33(entry.req.draws,    item.cost.draws);
  assign req_v     = add33(entry.req.vertices, item.cost.vertices);
  assign req_i     = add33(entry.req.indices,  item.cost.indices);
  assign req_items = add33(entry.req_items,    item.item_count);
  assign cand_d    = add33(used.draws,         item.cost.draws);
  assign cand_v    = add33(used.vertices,      item.cost.vertices);
  assign cand_i    = add33(used.indices,       item.cost.indices);
  assign acc_d     = add33(entry.acc.draws,    item.cost.draws);
  assign acc_v     = add33(entry.acc.vertices, item.cost.vertices);
  assign acc_i     = add33(entry.acc.indices,  item.cost.indices);
  assign acc_items = add33(entry.acc_items,    item.item_count);

  assign req_carry  = req_d[32] | req_v[32] | req_i[32];
  assign cand_carry = cand_d[32] | cand_v[32] | cand_i[32];
  assign acc_carry  = acc_d[32] | acc_v[32] | acc_i[32] | acc_items[32];
  assign frame_ok   = serial_nonzero && (max.draws != '0) && (max.vertices != '0)
                      && (max.indices != '0);

  always_comb begin
    entry_next = entry;
    used_next  = used;
    reason     = RSN_NONE;
    if (!consumer_ok) begin
      reason = RSN_INVALID_REQ;
    end else if (!entry.req_ok || !item.cost_valid || req_carry) begin
      // poison the requested totals until the next frame
      entry_next.req_ok = 1'b0;
      entry_next.req    = '0;
      reason            = RSN_OVERFLOW;
    end else begin
      entry_next.req = '{req_d[31:0], req_v[31:0], req_i[31:0]};
      if (req_items[32]) begin
        reason = RSN_OVERFLOW;
      end else begin
        entry_next.req_items = req_items[31:0];
        if (!frame_ok) begin
          reason = RSN_INVALID_FRAME;
        end else if (item.item_count == '0) begin
          reason = RSN_INVALID_REQ;
        end else if (cand_carry) begin
          reason = RSN_OVERFLOW;
        end else if (cand_d[31:0] > max.draws) begin
          reason = RSN_DRAW;
        end else if (cand_v[31:0] > max.vertices) begin
          reason = RSN_VERTEX;
        end else if (cand_i[31:0] > max.indices) begin
          reason = RSN_INDEX;
        end else if (acc_carry) begin
          reason = RSN_OVERFLOW;
        end else begin
          used_next            = '{cand_d[31:0], cand_v[31:0], cand_i[31:0]};
          entry_next.acc       = '{acc_d[31:0], acc_v[31:0], acc_i[31:0]};
          entry_next.acc_items = acc_items[31:0];
          entry_next.accepts   = sat_inc(entry.accepts);
        end
      end
    end
    if (consumer_ok && reason != RSN_NONE) begin
      entry_next.rejects = sat_inc(entry.rejects);
    end
  end

  assign dec.granted  = (reason == RSN_NONE);
  assign dec.reason   = reason;
  assign dec.overflow = (reason == RSN_OVERFLOW);

endmodule

// ===== sv/workload_budget_governor.sv =====
// Per-frame workload admission against draw, vertex and index budgets.
// Input channel: in_valid/in_stall carry one beat per item (mode, consumer,
// item_count, costs, cost_valid, frame_serial, held_last_complete).
// Output channel: out_valid/out_stall return exactly one result beat per
// input beat, in order: grant, reject reason, used totals, the named
// consumer's accept/reject counts and the frame event counters.
// Budgets are written through cfg_we/cfg_index/cfg_data (0 draws,
// 1 vertices, 2 indices); write them only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled; all
// checks for an item are done by one rank of 32-bit adders and compares
// on the named consumer's entry.
// A stalled output holds its beat; the input register keeps taking beats
// until it is full too, then in_stall rises.
// Reset clears budgets and all counters and leaves the frame invalid until
// a begin-frame beat with a nonzero serial arrives.
module workload_budget_governor #(
  parameter int NUM_CONSUMERS = wbg_pkg::NUM_CONSUMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [3:0]  consumer,
  input  logic [31:0] item_count,
  input  logic [31:0] cost_draws,
  input  logic [31:0] cost_vertices,
  input  logic [31:0] cost_indices,
  input  logic        cost_valid,
  input  logic [31:0] frame_serial,
  input  logic        held_last_complete,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        granted,
  output logic [2:0]  reject_reason,
  output logic [31:0] used_draws,
  output logic [31:0] used_vertices,
  output logic [31:0] used_indices,
  output logic [31:0] consumer_accepts,
  output logic [31:0] consumer_rejects,
  output logic [31:0] overflow_rejects,
  output logic [31:0] hold_count,
  output logic [31:0] invalidated_count
);
  import wbg_pkg::*;

  localparam int CW = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1;

  triple_t     max;
  logic        s1_valid;
  item_t       s1_item;
  logic        out_take, s1_fire;
  logic        serial_nonzero, serial_nonzero_next;
  triple_t     used, used_next, used_rsv;
  logic [31:0] ovf_cnt, ovf_cnt_next;
  logic [31:0] hold_cnt, hold_cnt_next;
  logic [31:0] inval_cnt, inval_cnt_next;
  logic [CW-1:0] idx;
  logic        consumer_ok, is_reserve, is_begin, is_fallback;
  entry_t      entry, entry_next;
  decision_t   dec;
  logic [31:0] acc_out, rej_out;

  // budget registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DRAWS:    max.draws    <= cfg_data;
        CFG_MAX_VERTICES: max.vertices <= cfg_data;
        CFG_MAX_INDICES:  max.indices  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_take = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_take;
  assign in_stall = s1_valid && !out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item <= '{mode, consumer, item_count,
                   '{cost_draws, cost_vertices, cost_indices},
                   cost_valid, frame_serial, held_last_complete};
    end
  end

  assign idx         = s1_item.consumer[CW-1:0];
  assign consumer_ok = {1'b0, s1_item.consumer} < 5'(NUM_CONSUMERS);
  assign is_reserve  = (s1_item.mode == MODE_RESERVE);
  assign is_begin    = (s1_item.mode == MODE_BEGIN);
  assign is_fallback = (s1_item.mode == MODE_FALLBACK);

  wbg_ledger #(
    .NUM_CONSUMERS(NUM_CONSUMERS),
    .CW(CW)
  ) u_ledger (
    .clk(clk),
    .rst(rst),
    .clr(s1_fire && is_begin),
    .we(s1_fire && is_reserve && consumer_ok),
    .widx(idx),
    .wdata(entry_next),
    .ridx(idx),
    .rdata(entry)
  );

  wbg_admit u_admit (
    .item(s1_item),
    .consumer_ok(consumer_ok),
    .entry(entry),
    .used(used),
    .max(max),
    .serial_nonzero(serial_nonzero),
    .dec(dec),
    .entry_next(entry_next),
    .used_next(used_rsv)
  );

  always_comb begin
    serial_nonzero_next = serial_nonzero;
    used_next           = used;
    ovf_cnt_next        = ovf_cnt;
    hold_cnt_next       = hold_cnt;
    inval_cnt_next      = inval_cnt;
    acc_out             = '0;
    rej_out             = '0;
    if (is_begin) begin
      serial_nonzero_next = (s1_item.frame_serial != '0);
      used_next           = '0;
      ovf_cnt_next        = '0;
      hold_cnt_next       = '0;
      inval_cnt_next      = '0;
    end else if (is_reserve) begin
      used_next = used_rsv;
      if (dec.overflow) begin
        ovf_cnt_next = sat_inc(ovf_cnt);
      end
      if (consumer_ok) begin
        acc_out = entry_next.accepts;
        rej_out = entry_next.rejects;
      end
    end else begin
      if (is_fallback) begin
        if (s1_item.held_last_complete) begin
          hold_cnt_next = sat_inc(hold_cnt);
        end else begin
          inval_cnt_next = sat_inc(inval_cnt);
        end
      end
      if (consumer_ok) begin
        acc_out = entry.accepts;
        rej_out = entry.rejects;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_nonzero <= 1'b0;
      used           <= '0;
      ovf_cnt        <= '0;
      hold_cnt       <= '0;
      inval_cnt      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        serial_nonzero <= serial_nonzero_next;
        used           <= used_next;
        ovf_cnt        <= ovf_cnt_next;
        hold_cnt       <= hold_cnt_next;
        inval_cnt      <= inval_cnt_next;
      end
    end
    if (s1_fire) begin
      granted           <= is_reserve && dec.granted;
      reject_reason     <= is_reserve ? dec.reason : RSN_NONE;
      used_draws        <= used_next.draws;
      used_vertices     <= used_next.vertices;
      used_indices      <= used_next.indices;
      consumer_accepts  <= acc_out;
      consumer_rejects  <= rej_out;
      overflow_rejects  <= ovf_cnt_next;
      hold_count        <= hold_cnt_next;
      invalidated_count <= inval_cnt_next;
    end
  end

  a_grant_no_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> reject_reason == RSN_NONE)
    else $error("grant beat carries a reject reason");

  a_grant_in_budget: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> used_draws <= max.draws && used_vertices <= max.vertices
                             && used_indices <= max.indices)
    else $error("granted beat exceeds a budget");

  a_begin_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && is_begin |=> used == '0 && ovf_cnt == '0 && !granted)
    else $error("begin frame left totals uncleared");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== test/workload_budget_governor_tb.sv =====
`timescale 1ns / 100ps

module workload_budget_governor_tb;
  import wbg_pkg::*;

  localparam int          NC          = NUM_CONSUMERS_DEF;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam int          LIMIT       = 500000;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_BEATS = 250;

  typedef struct packed {
    logic        granted;
    reason_t     reason;
    triple_t     used;
    logic [31:0] accepts;
    logic [31:0] rejects;
    logic [31:0] ovf;
    logic [31:0] holds;
    logic [31:0] invals;
  } tally_t;

  typedef struct {
    bit          cfg;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    item_t       it;
    bit          typed;
    reason_t     want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [3:0]  consumer;
  logic [31:0] item_count;
  logic [31:0] cost_draws;
  logic [31:0] cost_vertices;
  logic [31:0] cost_indices;
  logic        cost_valid;
  logic [31:0] frame_serial;
  logic        held_last_complete;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        granted;
  logic [2:0]  reject_reason;
  logic [31:0] used_draws;
  logic [31:0] used_vertices;
  logic [31:0] used_indices;
  logic [31:0] consumer_accepts;
  logic [31:0] consumer_rejects;
  logic [31:0] overflow_rejects;
  logic [31:0] hold_count;
  logic [31:0] invalidated_count;

  workload_budget_governor #(.NUM_CONSUMERS(NC)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .consumer(consumer),
    .item_count(item_count),
    .cost_draws(cost_draws),
    .cost_vertices(cost_vertices),
    .cost_indices(cost_indices),
    .cost_valid(cost_valid),
    .frame_serial(frame_serial),
    .held_last_complete(held_last_complete),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .granted(granted),
    .reject_reason(reject_reason),
    .used_draws(used_draws),
    .used_vertices(used_vertices),
    .used_indices(used_indices),
    .consumer_accepts(consumer_accepts),
    .consumer_rejects(consumer_rejects),
    .overflow_rejects(overflow_rejects),
    .hold_count(hold_count),
    .invalidated_count(invalidated_count)
  );

  // governor state as the testbench sees it
  triple_t     budget;
  bit          frame_live;
  triple_t     used_sum;
  triple_t     req_sum   [NC];
  bit          req_clean [NC];
  logic [31:0] req_items [NC];
  triple_t     acc_sum   [NC];
  logic [31:0] acc_items [NC];
  logic [31:0] acc_cnt   [NC];
  logic [31:0] rej_cnt   [NC];
  logic [31:0] ovf_cnt;
  logic [31:0] hold_cnt;
  logic [31:0] inval_cnt;

  tally_t      pending_tallies[$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          bursty = 1'b1;
  bit          stall_on = 1'b1;
  logic [15:0] stall_pat = '0;
  logic [5:0]  stall_phase = '0;

  function automatic logic [31:0] sat_bump(input logic [31:0] v);
    return (v == ALL_ONES) ? v : v + 32'd1;
  endfunction

  function automatic bit add3(input triple_t a, input triple_t b, output triple_t s);
    logic [32:0] d, v, x;
    d = {1'b0, a.draws} + {1'b0, b.draws};
    v = {1'b0, a.vertices} + {1'b0, b.vertices};
    x = {1'b0, a.indices} + {1'b0, b.indices};
    s = {d[31:0], v[31:0], x[31:0]};
    return !(d[32] | v[32] | x[32]);
  endfunction

  function automatic void clear_frame(input bit live);
    frame_live = live;
    used_sum = '0;
    for (int k = 0; k < NC; k++) begin
      req_sum[k]   = '0;
      req_clean[k] = 1'b1;
      req_items[k] = '0;
      acc_sum[k]   = '0;
      acc_items[k] = '0;
      acc_cnt[k]   = '0;
      rej_cnt[k]   = '0;
    end
    ovf_cnt   = '0;
    hold_cnt  = '0;
    inval_cnt = '0;
  endfunction

  function automatic reason_t refuse(input int c, input reason_t r);
    if (c < NC) rej_cnt[c] = sat_bump(rej_cnt[c]);
    if (r == RSN_OVERFLOW) ovf_cnt = sat_bump(ovf_cnt);
    return r;
  endfunction

  function automatic reason_t admit(input item_t it);
    int          c;
    triple_t     s, cand, acc;
    logic [32:0] w;
    c = int'(it.consumer);
    if (c >= NC) return refuse(c, RSN_INVALID_REQ);
    // a bad cost or an overflowing request poisons the consumer for the frame
    if (!req_clean[c] || !it.cost_valid || !add3(req_sum[c], it.cost, s)) begin
      req_clean[c] = 1'b0;
      req_sum[c]   = '0;
      return refuse(c, RSN_OVERFLOW);
    end
    req_sum[c] = s;
    w = {1'b0, req_items[c]} + {1'b0, it.item_count};
    if (w[32]) return refuse(c, RSN_OVERFLOW);
    req_items[c] = w[31:0];
    if (!frame_live || budget.draws == 0 || budget.vertices == 0 || budget.indices == 0)
      return refuse(c, RSN_INVALID_FRAME);
    if (it.item_count == 0) return refuse(c, RSN_INVALID_REQ);
    if (!add3(used_sum, it.cost, cand)) return refuse(c, RSN_OVERFLOW);
    if (cand.draws > budget.draws) return refuse(c, RSN_DRAW);
    if (cand.vertices > budget.vertices) return refuse(c, RSN_VERTEX);
    if (cand.indices > budget.indices) return refuse(c, RSN_INDEX);
    if (!add3(acc_sum[c], it.cost, acc)) return refuse(c, RSN_OVERFLOW);
    w = {1'b0, acc_items[c]} + {1'b0, it.item_count};
    if (w[32]) return refuse(c, RSN_OVERFLOW);
    used_sum     = cand;
    acc_sum[c]   = acc;
    acc_items[c] = w[31:0];
    acc_cnt[c]   = sat_bump(acc_cnt[c]);
    return RSN_NONE;
  endfunction

  function automatic tally_t govern(input item_t it);
    tally_t t;
    t = '0;
    case (it.mode)
      MODE_RESERVE: begin
        t.reason  = admit(it);
        t.granted = (t.reason == RSN_NONE);
      end
      MODE_BEGIN: clear_frame(it.frame_serial != 0);
      MODE_FALLBACK: begin
        if (it.held_last_complete) hold_cnt = sat_bump(hold_cnt);
        else inval_cnt = sat_bump(inval_cnt);
      end
      default: ;
    endcase
    t.used    = used_sum;
    t.accepts = (it.consumer < NC) ? acc_cnt[it.consumer] : '0;
    t.rejects = (it.consumer < NC) ? rej_cnt[it.consumer] : '0;
    t.ovf     = ovf_cnt;
    t.holds   = hold_cnt;
    t.invals  = inval_cnt;
    return t;
  endfunction

  function automatic logic [31:0] pick_cost(input logic [31:0] cap);
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return '0;
      2: return ALL_ONES;
      default: return $urandom_range(0, cap >> 3);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 74) it.mode = MODE_RESERVE;
    else if (pick < 82) it.mode = MODE_BEGIN;
    else if (pick < 97) it.mode = MODE_FALLBACK;
    else it.mode = MODE_UNUSED;
    it.consumer = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(NC, 15))
                                              : 4'($urandom_range(0, NC - 1));
    case ($urandom_range(0, 19))
      0: it.item_count = '0;
      1: it.item_count = $urandom;
      2: it.item_count = ALL_ONES;
      default: it.item_count = $urandom_range(1, 8);
    endcase
    it.cost.draws         = pick_cost(budget.draws);
    it.cost.vertices      = pick_cost(budget.vertices);
    it.cost.indices       = pick_cost(budget.indices);
    it.cost_valid         = ($urandom_range(0, 49) != 0);
    it.frame_serial       = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom);
    it.held_last_complete = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic row_t rsv(input logic [3:0] c, input logic [31:0] n, input logic [31:0] d,
                               input logic [31:0] v, input logic [31:0] x, input bit ok,
                               input reason_t want);
    row_t r;
    r.cfg     = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.it      = '0;
    r.it.mode       = MODE_RESERVE;
    r.it.consumer   = c;
    r.it.item_count = n;
    r.it.cost       = {d, v, x};
    r.it.cost_valid = ok;
    r.typed   = 1'b1;
    r.want    = want;
    return r;
  endfunction

  function automatic row_t ctl(input logic [1:0] m, input logic [31:0] serial, input bit held);
    row_t r;
    r.cfg     = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.it      = '0;
    r.it.mode               = m;
    r.it.frame_serial       = serial;
    r.it.held_last_complete = held;
    r.typed   = 1'b0;
    r.want    = RSN_NONE;
    return r;
  endfunction

  function automatic row_t cfg(input logic [1:0] idx, input logic [31:0] val);
    row_t r;
    r.cfg     = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.it      = '0;
    r.typed   = 1'b0;
    r.want    = RSN_NONE;
    return r;
  endfunction

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic cmp(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag(what, got, want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_MAX_DRAWS:    budget.draws    = val;
      CFG_MAX_VERTICES: budget.vertices = val;
      CFG_MAX_INDICES:  budget.indices  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold the input idle until every beat has come back, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (bursty && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
  endtask

  task automatic send(input item_t it, input bit typed, input reason_t want);
    tally_t t;
    @(negedge clk);
    in_valid           <= 1'b1;
    mode               <= it.mode;
    consumer           <= it.consumer;
    item_count         <= it.item_count;
    cost_draws         <= it.cost.draws;
    cost_vertices      <= it.cost.vertices;
    cost_indices       <= it.cost.indices;
    cost_valid         <= it.cost_valid;
    frame_serial       <= it.frame_serial;
    held_last_complete <= it.held_last_complete;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    t = govern(it);
    if (typed) begin
      t.reason  = want;
      t.granted = (it.mode == MODE_RESERVE) && (want == RSN_NONE);
    end
    pending_tallies.push_back(t);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat <= '0;
        1: stall_pat <= 16'($urandom | $urandom);
        default: stall_pat <= 16'($urandom & $urandom);
      endcase
    end
    out_stall <= stall_on && stall_pat[stall_phase[3:0]];
  end

  always @(posedge clk) begin : result_check
    tally_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tallies.size() == 0) begin
        flag("unexpected beat", {29'd0, reject_reason}, '0);
      end else begin
        w = pending_tallies.pop_front();
        cmp("granted", 32'(granted), 32'(w.granted));
        cmp("reject_reason", 32'(reject_reason), 32'(w.reason));
        cmp("used_draws", used_draws, w.used.draws);
        cmp("used_vertices", used_vertices, w.used.vertices);
        cmp("used_indices", used_indices, w.used.indices);
        cmp("consumer_accepts", consumer_accepts, w.accepts);
        cmp("consumer_rejects", consumer_rejects, w.rejects);
        cmp("overflow_rejects", overflow_rejects, w.ovf);
        cmp("hold_count", hold_count, w.holds);
        cmp("invalidated_count", invalidated_count, w.invals);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    row_t    plan[$];
    triple_t b;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_valid           = 1'b0;
    mode               = MODE_RESERVE;
    consumer           = '0;
    item_count         = '0;
    cost_draws         = '0;
    cost_vertices      = '0;
    cost_indices       = '0;
    cost_valid         = 1'b0;
    frame_serial       = '0;
    held_last_complete = 1'b0;
    budget             = '0;
    clear_frame(1'b0);

    // budgets start at zero and the frame starts invalid
    plan.push_back(rsv(0, 1, 1, 1, 1, 1, RSN_INVALID_FRAME));
    plan.push_back(ctl(MODE_BEGIN, 0, 0));
    plan.push_back(rsv(1, 0, 0, 0, 0, 1, RSN_INVALID_FRAME));
    plan.push_back(cfg(CFG_MAX_DRAWS, 10));
    plan.push_back(cfg(CFG_MAX_VERTICES, 100));
    plan.push_back(cfg(CFG_MAX_INDICES, 1000));
    plan.push_back(ctl(MODE_BEGIN, ALL_ONES, 0));
    plan.push_back(rsv(0, 0, 1, 1, 1, 1, RSN_INVALID_REQ));
    plan.push_back(rsv(15, 1, 0, 0, 0, 1, RSN_INVALID_REQ));
    plan.push_back(rsv(NC, 1, 0, 0, 0, 1, RSN_INVALID_REQ));
    plan.push_back(rsv(0, 1, 10, 100, 1000, 1, RSN_NONE));
    plan.push_back(rsv(1, 1, 1, 0, 0, 1, RSN_DRAW));
    plan.push_back(rsv(1, 1, 0, 1, 0, 1, RSN_VERTEX));
    plan.push_back(rsv(1, 1, 0, 0, 1, 1, RSN_INDEX));
    // invalid cost, then the poisoned consumer keeps overflowing
    plan.push_back(rsv(2, 1, 0, 0, 0, 0, RSN_OVERFLOW));
    plan.push_back(rsv(2, 1, 0, 0, 0, 1, RSN_OVERFLOW));
    plan.push_back(ctl(MODE_FALLBACK, 0, 1));
    plan.push_back(ctl(MODE_FALLBACK, 0, 0));
    plan.push_back(ctl(MODE_UNUSED, ALL_ONES, 1));
    plan.push_back(ctl(MODE_BEGIN, 1, 0));
    plan.push_back(cfg(CFG_MAX_DRAWS, ALL_ONES));
    plan.push_back(cfg(CFG_MAX_VERTICES, ALL_ONES));
    plan.push_back(cfg(CFG_MAX_INDICES, ALL_ONES));
    plan.push_back(rsv(3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1, RSN_NONE));
    // item sum overflow, used sum overflow, requested cost overflow
    plan.push_back(rsv(3, 1, 0, 0, 0, 1, RSN_OVERFLOW));
    plan.push_back(rsv(2, 1, 1, 0, 0, 1, RSN_OVERFLOW));
    plan.push_back(rsv(3, 1, ALL_ONES, ALL_ONES, ALL_ONES, 1, RSN_OVERFLOW));
    plan.push_back(rsv(3, 1, 0, 0, 0, 1, RSN_OVERFLOW));
    plan.push_back(cfg(CFG_MAX_INDICES, 0));
    plan.push_back(rsv(0, 1, 0, 0, 0, 1, RSN_INVALID_FRAME));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        pace();
        send(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      bursty   = (ph != 1 && ph != 5);
      stall_on = (ph % 3 != 1);
      case (ph)
        0: b = {32'd12, 32'd120, 32'd1200};
        1: b = {ALL_ONES, ALL_ONES, ALL_ONES};
        2: b = {32'($urandom) | 32'd1, 32'($urandom) | 32'd1, 32'($urandom) | 32'd1};
        3: b = {32'd1, 32'd1, 32'd1};
        4: b = {32'd40, 32'd0, 32'd400};
        5: b = {32'd64, 32'd1000, 32'd5000};
        6: b = {32'($urandom_range(1, 200)), 32'($urandom_range(1, 200)),
                32'($urandom_range(1, 200))};
        default: b = {ALL_ONES, 32'd30, ALL_ONES};
      endcase
      write_reg(CFG_MAX_DRAWS, b.draws);
      write_reg(CFG_MAX_VERTICES, b.vertices);
      write_reg(CFG_MAX_INDICES, b.indices);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        pace();
        send(rand_item(), 1'b0, RSN_NONE);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending_tallies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
